// ----- hw/rtl/adckd_pkg.sv -----
// Shared constants, types and register map of the keypad debouncer.
`default_nettype none

package adckd_pkg;

	localparam int KEY_COUNT   = 5;
	localparam int SAMPLE_BITS = 10;

	localparam int MASK_BITS = 5;
	localparam int KEY_BITS  = 3;
	localparam int THR_BITS  = 10;
	localparam int THR_COUNT = 5;
	localparam int CNT_BITS  = 8;
	localparam int CMP_BITS  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;
	localparam int REG_IDX_BITS  = 3;

	localparam logic [KEY_BITS-1:0] NO_KEY = KEY_BITS'(5);

	localparam logic [REG_IDX_BITS-1:0] REG_THR0    = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_THR1    = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_THR2    = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_THR3    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_THR4    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_CEILING = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_PRESS   = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 3'd7;

	localparam logic [THR_BITS-1:0] THR_RESET [THR_COUNT] = '{
		10'd50, 10'd200, 10'd400, 10'd600, 10'd800
	};
	localparam logic [CNT_BITS-1:0] CEILING_RESET = 8'd15;
	localparam logic [CNT_BITS-1:0] PRESS_RESET   = 8'd10;
	localparam logic [CNT_BITS-1:0] RELEASE_RESET = 8'd3;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_CLEAR  = 2'd2
	} adckd_cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] ceiling;
		logic [CNT_BITS-1:0] press_lvl;
		logic [CNT_BITS-1:0] release_lvl;
	} adckd_lvl_t;

	typedef struct packed {
		logic       step;
		adckd_cmd_t command;
		logic       sel;
		logic       ack;
	} adckd_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/adckd_sample_if.sv -----
// Input channel: command, converter sample and acknowledge mask.
`default_nettype none

interface adckd_sample_if import adckd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             command;
	logic [SAMPLE_BITS-1:0] adc_value;
	logic [MASK_BITS-1:0]   ack_mask;

	modport source (output valid, command, adc_value, ack_mask, input ready);
	modport sink (input valid, command, adc_value, ack_mask, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adckd_status_if.sv -----
// Result channel: decoded key and debounced key masks.
`default_nettype none

interface adckd_status_if import adckd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KEY_BITS-1:0]  decoded_key;
	logic [MASK_BITS-1:0] pressed_mask;
	logic [MASK_BITS-1:0] new_press_mask;

	modport source (output valid, decoded_key, pressed_mask, new_press_mask, input ready);
	modport sink (input valid, decoded_key, pressed_mask, new_press_mask, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adckd_key_cell.sv -----
// Debounce counter, pressed status and new-press flag of one key.
`default_nettype none

module adckd_key_cell import adckd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire adckd_ctl_t ctl,
	input  wire adckd_lvl_t lvl,
	output logic            pressed,
	output logic            flag
);

	logic [CNT_BITS-1:0] cnt_q;
	logic                pressed_q;
	logic                flag_q;
	logic [CNT_BITS-1:0] cnt_d;
	logic                pressed_d;
	logic                flag_d;
	logic [CNT_BITS-1:0] inc;
	logic [CNT_BITS-1:0] dec;

	always_comb begin
		inc       = cnt_q + CNT_BITS'(1);
		dec       = cnt_q - CNT_BITS'(1);
		cnt_d     = cnt_q;
		pressed_d = pressed_q;
		flag_d    = flag_q;
		case (ctl.command)
			CMD_SAMPLE: begin
				if (ctl.sel) begin
					if (cnt_q < lvl.ceiling) begin
						cnt_d = inc;
						if (inc > lvl.press_lvl && !pressed_q) begin
							pressed_d = 1'b1;
							flag_d    = 1'b1;
						end
					end
				end else if (cnt_q != '0) begin
					cnt_d  = dec;
					flag_d = 1'b0;
					if (dec < lvl.release_lvl) begin
						pressed_d = 1'b0;
					end
				end
			end
			CMD_ACK: begin
				flag_d = flag_q & ~ctl.ack;
			end
			CMD_CLEAR: begin
				cnt_d     = '0;
				pressed_d = 1'b0;
				flag_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pressed_q <= 1'b0;
			flag_q    <= 1'b0;
		end else if (ctl.step) begin
			cnt_q     <= cnt_d;
			pressed_q <= pressed_d;
			flag_q    <= flag_d;
		end
	end

	assign pressed = pressed_q;
	assign flag    = flag_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adc_keypad_debouncer.sv -----
// Top level of the resistor-ladder keypad debouncer.
// Usage:
//   keys   : input items (command, adc_value, ack_mask), valid/ready handshake.
//   status : one result item per input item (decoded_key, pressed_mask,
//            new_press_mask), valid/ready handshake.
//   APB    : threshold and level registers at byte address 4*i, writes and reads.
// An accepted item lands in an input register; while it waits there the key
// decode and all five counter updates run in parallel, and the result is
// registered once the output side can advance. One item per cycle is sustained
// while the status side does not stall the result register.
// A stalled result holds in the output register while one more item waits in
// the input register; ready drops only when both are full.
// Reset clears counters, status, flags and the pipeline, and loads the
// registers with their default thresholds and levels. The clear command
// zeroes counters, status and flags without touching the registers.
`default_nettype none

module adc_keypad_debouncer import adckd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	adckd_sample_if.sink                  keys,
	adckd_status_if.source                status,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready
);

	logic [THR_BITS-1:0]     thr_q [THR_COUNT];
	adckd_lvl_t              lvl_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    reg_wr;

	logic                    valid_s1;
	adckd_cmd_t              command_s1;
	logic [SAMPLE_BITS-1:0]  adc_s1;
	logic [MASK_BITS-1:0]    ack_s1;

	logic                    out_valid_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    adv;
	logic                    step;
	logic [KEY_BITS-1:0]     key_dec;
	wire  [MASK_BITS-1:0]    pressed_all;
	wire  [MASK_BITS-1:0]    flag_all;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THR_COUNT; i++) begin
				thr_q[i] <= THR_RESET[i];
			end
			lvl_q.ceiling     <= CEILING_RESET;
			lvl_q.press_lvl   <= PRESS_RESET;
			lvl_q.release_lvl <= RELEASE_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_THR0:    thr_q[0]          <= pwdata[THR_BITS-1:0];
				REG_THR1:    thr_q[1]          <= pwdata[THR_BITS-1:0];
				REG_THR2:    thr_q[2]          <= pwdata[THR_BITS-1:0];
				REG_THR3:    thr_q[3]          <= pwdata[THR_BITS-1:0];
				REG_THR4:    thr_q[4]          <= pwdata[THR_BITS-1:0];
				REG_CEILING: lvl_q.ceiling     <= pwdata[CNT_BITS-1:0];
				REG_PRESS:   lvl_q.press_lvl   <= pwdata[CNT_BITS-1:0];
				REG_RELEASE: lvl_q.release_lvl <= pwdata[CNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THR0:    prdata = APB_DATA_BITS'(thr_q[0]);
			REG_THR1:    prdata = APB_DATA_BITS'(thr_q[1]);
			REG_THR2:    prdata = APB_DATA_BITS'(thr_q[2]);
			REG_THR3:    prdata = APB_DATA_BITS'(thr_q[3]);
			REG_THR4:    prdata = APB_DATA_BITS'(thr_q[4]);
			REG_CEILING: prdata = APB_DATA_BITS'(lvl_q.ceiling);
			REG_PRESS:   prdata = APB_DATA_BITS'(lvl_q.press_lvl);
			REG_RELEASE: prdata = APB_DATA_BITS'(lvl_q.release_lvl);
			default:     prdata = '0;
		endcase
	end

	// input register and handshake
	assign adv        = !out_valid_q || status.ready;
	assign step       = adv && valid_s1;
	assign keys.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.valid && keys.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			command_s1 <= adckd_cmd_t'(keys.command);
			adc_s1     <= keys.adc_value;
			ack_s1     <= keys.ack_mask;
		end
	end

	// first key whose threshold lies above the sample
	always_comb begin
		key_dec = NO_KEY;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (CMP_BITS'(adc_s1) < CMP_BITS'(thr_q[k])) begin
				key_dec = KEY_BITS'(k);
			end
		end
	end

	for (genvar k = 0; k < MASK_BITS; k++) begin : g_key
		if (k < KEY_COUNT) begin : g_cell
			adckd_ctl_t ctl;

			assign ctl.step    = step;
			assign ctl.command = command_s1;
			assign ctl.sel     = (key_dec == KEY_BITS'(k));
			assign ctl.ack     = ack_s1[k];

			adckd_key_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.lvl     (lvl_q),
				.pressed (pressed_all[k]),
				.flag    (flag_all[k])
			);
		end else begin : g_absent
			assign pressed_all[k] = 1'b0;
			assign flag_all[k]    = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			key_q <= (command_s1 == CMD_SAMPLE) ? key_dec : NO_KEY;
		end
	end

	assign status.valid          = out_valid_q;
	assign status.decoded_key    = key_q;
	assign status.pressed_mask   = pressed_all;
	assign status.new_press_mask = flag_all;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		step && command_s1 == CMD_CLEAR |=> pressed_all == '0 && flag_all == '0)
		else $error("state not cleared by clear command");

	a_flag_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(flag_all & ~pressed_all) == '0)
		else $error("new-press flag set on a key that is not pressed");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.valid |-> status.decoded_key <= NO_KEY)
		else $error("decoded key out of range");

	a_masks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pressed_all) && $stable(flag_all))
		else $error("key state moved without a step");

endmodule

`default_nettype wire
